[sv/lc4b5b_pkg.sv]
// Shared types and 4B5B symbol tables for the byte codec.
// No dependencies; lc4b5b_step and the codec core import this package.
package lc4b5b_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned AccW  = 16;
  localparam int unsigned FillW = 5;
  localparam int unsigned SymW  = 5;

  // result queue depth; pointers wrap on their own, so keep a power of two
  localparam int unsigned QDepth = 4;

  localparam logic DirEncode = 1'b0;
  localparam logic DirDecode = 1'b1;

  typedef struct packed {
    logic [ByteW-1:0] out_byte;
    logic             code_error;
    logic             last_of_run;
  } lc4b5b_res_t;

  // Next accumulator state and the results one input byte produces.
  typedef struct packed {
    logic [AccW-1:0]  acc;
    logic [FillW-1:0] fill;
    logic [1:0]       count;
    lc4b5b_res_t      res0;
    lc4b5b_res_t      res1;
  } lc4b5b_step_t;

  function automatic logic [SymW-1:0] enc_sym(input logic [3:0] nib);
    logic [SymW-1:0] s;
    case (nib)
      4'h0:    s = 5'h1e;
      4'h1:    s = 5'h09;
      4'h2:    s = 5'h14;
      4'h3:    s = 5'h15;
      4'h4:    s = 5'h0a;
      4'h5:    s = 5'h0b;
      4'h6:    s = 5'h0e;
      4'h7:    s = 5'h0f;
      4'h8:    s = 5'h12;
      4'h9:    s = 5'h13;
      4'ha:    s = 5'h16;
      4'hb:    s = 5'h17;
      4'hc:    s = 5'h1a;
      4'hd:    s = 5'h1b;
      4'he:    s = 5'h1c;
      default: s = 5'h1d;
    endcase
    return s;
  endfunction

  // Bit 5 flags a non-data symbol; then the low bits carry the symbol itself.
  function automatic logic [SymW:0] dec_sym(input logic [SymW-1:0] sym);
    logic [SymW:0] r;
    case (sym)
      5'h1e:   r = {1'b0, 5'h00};
      5'h09:   r = {1'b0, 5'h01};
      5'h14:   r = {1'b0, 5'h02};
      5'h15:   r = {1'b0, 5'h03};
      5'h0a:   r = {1'b0, 5'h04};
      5'h0b:   r = {1'b0, 5'h05};
      5'h0e:   r = {1'b0, 5'h06};
      5'h0f:   r = {1'b0, 5'h07};
      5'h12:   r = {1'b0, 5'h08};
      5'h13:   r = {1'b0, 5'h09};
      5'h16:   r = {1'b0, 5'h0a};
      5'h17:   r = {1'b0, 5'h0b};
      5'h1a:   r = {1'b0, 5'h0c};
      5'h1b:   r = {1'b0, 5'h0d};
      5'h1c:   r = {1'b0, 5'h0e};
      5'h1d:   r = {1'b0, 5'h0f};
      default: r = {1'b1, sym};
    endcase
    return r;
  endfunction

endpackage

[sv/lc4b5b_in_if.sv]
// Input channel of the 4B5B byte codec: valid/ready plus one byte.
// Depends on nothing.
interface lc4b5b_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

[sv/lc4b5b_out_if.sv]
// Result channel of the 4B5B byte codec: valid/ready plus byte and flags.
// Depends on nothing.
interface lc4b5b_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       code_error;
  logic       last_of_run;

  modport source (output valid, output out_byte, output code_error,
                  output last_of_run, input ready);
  modport sink (input valid, input out_byte, input code_error,
                input last_of_run, output ready);
endinterface

[sv/lc4b5b_step.sv]
// Per-byte datapath: merges a byte or code word into the bit accumulator
// and splits off finished results. Depends on lc4b5b_pkg.
module lc4b5b_step
  import lc4b5b_pkg::*;
(
  input  logic             dir_i,
  input  logic [AccW-1:0]  acc_i,
  input  logic [FillW-1:0] fill_i,
  input  logic [ByteW-1:0] byte_i,
  output lc4b5b_step_t     step_o
);

  logic [9:0]       code;
  logic [AccW-1:0]  enc_sum;
  logic [AccW-1:0]  dec_sum;
  logic [FillW-1:0] enc_fill;
  logic [FillW-1:0] dec_fill;
  logic [SymW:0]    hi_dec;
  logic [SymW:0]    lo_dec;
  logic [ByteW-1:0] dec_byte;

  assign code     = {enc_sym(byte_i[7:4]), enc_sym(byte_i[3:0])};
  assign enc_sum  = acc_i | (AccW'(code) << fill_i[3:0]);
  assign dec_sum  = acc_i | (AccW'(byte_i) << fill_i[3:0]);
  assign enc_fill = fill_i + FillW'(10);
  assign dec_fill = fill_i + FillW'(8);

  assign hi_dec   = dec_sym(dec_sum[9:5]);
  assign lo_dec   = dec_sym(dec_sum[4:0]);
  // bad high symbol keeps only its low four bits; bad low symbol ORs into bit 4
  assign dec_byte = {hi_dec[3:0], 4'b0000} | {3'b000, lo_dec[SymW-1:0]};

  always_comb begin
    step_o = '0;
    if (dir_i == DirEncode) begin
      step_o.res0.out_byte = enc_sum[7:0];
      step_o.res1.out_byte = enc_sum[15:8];
      if (enc_fill >= FillW'(16)) begin
        step_o.count            = 2'd2;
        step_o.res1.last_of_run = 1'b1;
        step_o.acc              = '0;
        step_o.fill             = '0;
      end else begin
        step_o.count            = 2'd1;
        step_o.res0.last_of_run = 1'b1;
        step_o.acc              = enc_sum >> 8;
        step_o.fill             = enc_fill - FillW'(8);
      end
    end else begin
      step_o.res0.out_byte    = dec_byte;
      step_o.res0.code_error  = hi_dec[SymW] | lo_dec[SymW];
      step_o.res0.last_of_run = 1'b1;
      if (dec_fill >= FillW'(10)) begin
        step_o.count = 2'd1;
        step_o.acc   = dec_sum >> 10;
        step_o.fill  = dec_fill - FillW'(10);
      end else begin
        step_o.count = 2'd0;
        step_o.acc   = dec_sum;
        step_o.fill  = dec_fill;
      end
    end
  end

endmodule

[sv/line_code_4b5b_byte_codec_core.sv]
// Channel   Dir  Handshake      Payload
// in_i      in   valid/ready    in_byte[7:0]
// out_o     out  valid/ready    out_byte[7:0], code_error, last_of_run
// cfg       in   cfg_we_i       cfg_wdata_i (direction)
//
// An accepted byte updates the accumulator in the same cycle and its
// results land in a four-entry result queue; the first result is offered
// the next cycle. The queue drains one beat per cycle while out_o.ready
// is high. Encoding turns every four inputs into five bytes out. in_i.ready
// is high while the queue has room for two results; it falls under output
// stall and when encoded inputs arrive faster than the queue drains.
// Reset clears the accumulator, queue and direction (encode).
// Depends on lc4b5b_pkg, lc4b5b_in_if, lc4b5b_out_if, lc4b5b_step.
module line_code_4b5b_byte_codec_core
  import lc4b5b_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  lc4b5b_in_if.sink   in_i,
  lc4b5b_out_if.source out_o
);

  localparam int unsigned PtrW = $clog2(QDepth);
  localparam int unsigned CntW = $clog2(QDepth + 1);

  logic             dir_q;
  logic [AccW-1:0]  acc_q;
  logic [FillW-1:0] fill_q;
  lc4b5b_step_t     step;

  lc4b5b_res_t      q_mem [QDepth];
  logic [PtrW-1:0]  wr_q, rd_q;
  logic [CntW-1:0]  cnt_q;
  logic             push, pop;
  logic [CntW-1:0]  push_n;
  logic [PtrW-1:0]  wr_nxt;

  lc4b5b_step u_step (
    .dir_i  (dir_q),
    .acc_i  (acc_q),
    .fill_i (fill_q),
    .byte_i (in_i.in_byte),
    .step_o (step)
  );

  assign in_i.ready = (cnt_q <= CntW'(QDepth - 2));
  assign push       = in_i.valid & in_i.ready;
  assign pop        = out_o.valid & out_o.ready;
  assign push_n     = push ? CntW'(step.count) : '0;
  assign wr_nxt     = wr_q + PtrW'(1);

  assign out_o.valid       = (cnt_q != '0);
  assign out_o.out_byte    = q_mem[rd_q].out_byte;
  assign out_o.code_error  = q_mem[rd_q].code_error;
  assign out_o.last_of_run = q_mem[rd_q].last_of_run;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q  <= DirEncode;
      acc_q  <= '0;
      fill_q <= '0;
    end else if (cfg_we_i) begin
      dir_q  <= cfg_wdata_i;
      acc_q  <= '0;
      fill_q <= '0;
    end else if (push) begin
      acc_q  <= step.acc;
      fill_q <= step.fill;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + PtrW'(push_n);
      rd_q  <= rd_q + PtrW'(pop);
      cnt_q <= cnt_q + push_n - CntW'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push && step.count != 2'd0) begin
      q_mem[wr_q] <= step.res0;
    end
    if (push && step.count == 2'd2) begin
      q_mem[wr_nxt] <= step.res1;
    end
  end

endmodule

[sv/lc4b5b_chk.sv]
// Port-level checker for the 4B5B byte codec, bound to the top level.
// Depends on line_code_4b5b_byte_codec_core.
module lc4b5b_chk (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       cfg_we_i,
  input logic       cfg_wdata_i,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] out_byte_i,
  input logic       code_error_i,
  input logic       last_of_run_i
);

  logic dir_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q <= 1'b0;
    end else if (cfg_we_i) begin
      dir_q <= cfg_wdata_i;
    end
  end

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(out_byte_i) && $stable(code_error_i)
      && $stable(last_of_run_i))
    else $error("result beat changed under stall");

  // every encoded byte yields at least one result
  a_enc_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && !dir_q && !cfg_we_i |=> out_valid_i)
    else $error("encode input gave no result");

  // decode results are single, so an error beat always closes its run
  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && code_error_i |-> last_of_run_i)
    else $error("code_error on a non-final beat");

  // input backpressure only while results are queued
  a_ready_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i)
    else $error("input stalled with empty result queue");

endmodule

bind line_code_4b5b_byte_codec_core lc4b5b_chk u_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .cfg_we_i      (cfg_we_i),
  .cfg_wdata_i   (cfg_wdata_i),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_byte_i    (out_o.out_byte),
  .code_error_i  (out_o.code_error),
  .last_of_run_i (out_o.last_of_run)
);
